>>> src/rhtc_pkg.sv
package rhtc_pkg;

    // field widths
    localparam int RH_W   = 12;
    localparam int T_W    = 14;
    localparam int TOUT_W = 12;
    localparam int HOUT_W = 10;

    // temperature: (t - 4500) / 10, truncated toward zero
    localparam logic signed [14:0] T_OFFSET    = 15'sd4500;
    localparam logic [15:0]        DIV10_RECIP = 16'd52429;
    localparam int                 DIV10_SHIFT = 19;

    // humidity polynomial, scaled by 10^6
    localparam logic signed [14:0] H_T_OFFSET = 15'sd7000;
    localparam logic [15:0]        H_BASE     = 16'd1000;
    localparam logic [30:0]        RH_GAIN    = 31'd405000;
    localparam logic signed [31:0] N_OFFSET   = 32'sd40000000;
    localparam logic signed [31:0] N_CEIL     = 32'sd1000000000;
    localparam logic signed [31:0] N_FLOOR    = 32'sd1000000;

    // n / 10^6 for 0 <= n < 2^30 as (n * ceil(2^50 / 10^6)) >> 50
    localparam logic [30:0] DIV_E6_RECIP = 31'd1125899907;
    localparam int          DIV_E6_SHIFT = 50;

    localparam logic [HOUT_W-1:0] HUMI_CEIL  = 10'd1000;
    localparam logic [HOUT_W-1:0] HUMI_FLOOR = 10'd1;

    typedef struct packed {
        logic [RH_W-1:0] raw_humidity;
        logic [T_W-1:0]  raw_temperature;
    } rhtc_in_t;

    typedef struct packed {
        logic signed [TOUT_W-1:0] temperature_tenths;
        logic [HOUT_W-1:0]        humidity_tenths;
    } rhtc_out_t;

    // after the products
    typedef struct packed {
        logic signed [31:0] lin_term;
        logic [28:0]        quad_term;
        logic [30:0]        rh_term;
        logic [T_W-1:0]     t_mag;
        logic               t_neg;
    } rhtc_prod_t;

    // after the sum and the temperature divide
    typedef struct packed {
        logic [29:0]              n_mag;
        logic                     n_high;
        logic                     n_low;
        logic signed [TOUT_W-1:0] temperature_tenths;
    } rhtc_sum_t;

endpackage

>>> src/rhtc_mult.sv
module rhtc_mult
    import rhtc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       valid,
    input  rhtc_in_t   sample,
    output logic       prod_valid,
    output rhtc_prod_t prod
);

    logic              valid_reg;
    rhtc_prod_t        prod_reg;
    rhtc_prod_t        prod_next;
    logic signed [14:0] dt;
    logic signed [14:0] dtemp;
    logic [15:0]        gain;
    logic [23:0]        rh_sq;

    always_comb
    begin
        dt    = $signed({1'b0, sample.raw_temperature}) - H_T_OFFSET;
        gain  = H_BASE + {1'b0, sample.raw_humidity, 3'b000};
        rh_sq = 24'(sample.raw_humidity) * 24'(sample.raw_humidity);
        dtemp = $signed({1'b0, sample.raw_temperature}) - T_OFFSET;

        prod_next.lin_term  = dt * $signed({1'b0, gain});
        // 28 * rh^2 as 32x - 4x
        prod_next.quad_term = {rh_sq, 5'b00000} - {3'b000, rh_sq, 2'b00};
        prod_next.rh_term   = 31'(sample.raw_humidity) * RH_GAIN;
        prod_next.t_neg     = dtemp[14];
        prod_next.t_mag     = dtemp[14] ? T_W'(-dtemp) : T_W'(dtemp);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod_valid = valid_reg;
    assign prod       = prod_reg;

endmodule

>>> src/rhtc_sum.sv
module rhtc_sum
    import rhtc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       prod_valid,
    input  rhtc_prod_t prod,
    output logic       sum_valid,
    output rhtc_sum_t  sum
);

    logic               valid_reg;
    rhtc_sum_t          sum_reg;
    rhtc_sum_t          sum_next;
    logic signed [31:0] n;
    logic [29:0]        t_prod;
    logic [10:0]        t_quot;

    always_comb
    begin
        n = prod.lin_term
          - $signed({3'b000, prod.quad_term})
          + $signed({1'b0, prod.rh_term})
          - N_OFFSET;

        // divide by ten through the reciprocal
        t_prod = 30'(prod.t_mag) * 30'(DIV10_RECIP);
        t_quot = t_prod[29:DIV10_SHIFT];

        sum_next.n_mag  = n[29:0];
        sum_next.n_high = n > N_CEIL;
        sum_next.n_low  = n < N_FLOOR;
        sum_next.temperature_tenths = prod.t_neg ? -$signed({1'b0, t_quot})
                                                 :  $signed({1'b0, t_quot});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= prod_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    assign sum_valid = valid_reg;
    assign sum       = sum_reg;

endmodule

>>> src/rhtc_scale.sv
module rhtc_scale
    import rhtc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      sum_valid,
    input  rhtc_sum_t sum,
    output logic      done,
    output rhtc_out_t result
);

    logic        done_reg;
    rhtc_out_t   result_reg;
    rhtc_out_t   result_next;
    logic [60:0] h_prod;
    logic [10:0] h_quot;

    always_comb
    begin
        h_prod = 61'(sum.n_mag) * 61'(DIV_E6_RECIP);
        h_quot = h_prod[60:DIV_E6_SHIFT];

        result_next.temperature_tenths = sum.temperature_tenths;
        if (sum.n_high)
        begin
            result_next.humidity_tenths = HUMI_CEIL;
        end
        else if (sum.n_low)
        begin
            result_next.humidity_tenths = HUMI_FLOOR;
        end
        else
        begin
            result_next.humidity_tenths = h_quot[HOUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= sum_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> src/humidity_temp_compensation.sv
// a transfer taken at an edge passes the input register, product stage, sum stage and
//   result register before its result strobes on done
// throughput: one transfer per clock; busy is always low and the pipeline never stalls
// the receiver cannot stall, so every result is shown for exactly one cycle
// reset: rst_n asynchronous active low, clears all valid bits; payload registers keep
//   whatever they hold and no result is shown until a new transfer comes through
module humidity_temp_compensation
    import rhtc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  rhtc_in_t  sample,
    output logic      done,
    output rhtc_out_t result
);

    // input register
    logic       in_valid_reg;
    rhtc_in_t   in_reg;

    // stage links
    logic       prod_valid;
    rhtc_prod_t prod;
    logic       sum_valid;
    rhtc_sum_t  sum;

    // every stage moves forward each cycle, so a transfer is always taken
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    // payload captured unconditionally, the valid bit qualifies it
    always_ff @(posedge clk)
    begin
        in_reg <= sample;
    end

    // products: (t - 7000)(1000 + 8rh), 28rh^2, 405000rh and |t - 4500|
    rhtc_mult u_mult (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (in_valid_reg),
        .sample     (in_reg),
        .prod_valid (prod_valid),
        .prod       (prod)
    );

    // polynomial sum with its clamp flags, and temperature divided by ten
    rhtc_sum u_sum (
        .clk        (clk),
        .rst_n      (rst_n),
        .prod_valid (prod_valid),
        .prod       (prod),
        .sum_valid  (sum_valid),
        .sum        (sum)
    );

    // humidity sum divided by 10^6 with clamp to 1..1000, into the result register
    rhtc_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .sum_valid (sum_valid),
        .sum       (sum),
        .done      (done),
        .result    (result)
    );

endmodule

>>> src/rhtc_checker.sv
module rhtc_checker
    import rhtc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      done,
    input rhtc_out_t result
);

    // never holds off a transfer
    assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // every transfer gives a result on done
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |-> ##4 done)
        else $error("result missing");

    // no result without an earlier transfer
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(start && !busy, 4))
        else $error("result without transfer");

    // results stay in their ranges
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.humidity_tenths >= HUMI_FLOOR && result.humidity_tenths <= HUMI_CEIL
              && $signed(result.temperature_tenths) >= -12'sd450
              && $signed(result.temperature_tenths) <= 12'sd1188))
        else $error("result out of range");

endmodule

bind humidity_temp_compensation rhtc_checker u_rhtc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
